[rtl/core/kea_pkg.sv]
// ----------------------------------------------------------------------------
// kea_pkg
// Shared types and constants for the eccentric anomaly bisection solver.
// ----------------------------------------------------------------------------
package kea_pkg;

  // Number of halvings requested; more than 32 cannot move the lower bound.
  localparam int unsigned BisectionSteps = 32;
  localparam int unsigned NumSteps = (BisectionSteps > 32) ? 32 : BisectionSteps;

  // Register stages in one bisection step.
  localparam int unsigned StepStages = 25;

  // Number of Taylor iterations in the sine accumulator.
  localparam int unsigned TaylorTerms = 6;

  localparam logic [30:0] OneQ30      = 31'h4000_0000;
  localparam logic [30:0] HalfPiQ30   = 31'd1686629713;
  localparam logic [29:0] InvTwoPiQ32 = 30'd683565276;

  // Taylor divisors and floor(2^32 / d) for each.
  localparam logic [7:0]  TaylorDiv [TaylorTerms] = '{8'd156, 8'd110, 8'd72,
                                                      8'd42, 8'd20, 8'd6};
  localparam logic [29:0] TaylorRcp [TaylorTerms] = '{30'd27531841, 30'd39045157,
                                                      30'd59652323, 30'd102261126,
                                                      30'd214748364, 30'd715827882};

  // Item carried from one bisection step to the next.
  typedef struct packed {
    logic        byp;
    logic [31:0] m;
    logic [31:0] lower;
  } item_t;

endpackage

[rtl/core/kepler_eccentric_anomaly_bisect.sv]
// ----------------------------------------------------------------------------
// kepler_eccentric_anomaly_bisect
// Pipelined bisection solver of E - e*sin(E) = M on 32-bit binary angles.
// ----------------------------------------------------------------------------
// Takes one mean anomaly per cycle while the pipeline is not stalled and
// returns its eccentric anomaly after kea_pkg::NumSteps bisection steps of
// kea_pkg::StepStages register stages each; throughput is one transaction
// per cycle, set by the fully unrolled chain of steps, each with its own
// sine unit and multipliers. The whole pipeline advances together: while a
// result is held by out_stall_i, in_stall_o is raised. A mean anomaly of
// zero, or an eccentricity of zero, is passed straight through the
// same pipeline. The eccentricity register is written over the cfg channel,
// which is always ready; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module kepler_eccentric_anomaly_bisect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] mean_anomaly_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] solved_anomaly_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] eccentricity_q16_i
);

  localparam int unsigned NSteps = kea_pkg::NumSteps;

  logic [15:0]    ecc_q;
  logic           en;
  logic           vld   [NSteps+1];
  kea_pkg::item_t item  [NSteps+1];

  // Global advance: hold everything while the last stage is stalled.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q <= '0;
    end else if (cfg_valid_i) begin
      ecc_q <= eccentricity_q16_i;
    end
  end

  assign vld[0]        = in_valid_i;
  assign item[0].byp   = (mean_anomaly_i == 32'd0) || (ecc_q == 16'd0);
  assign item[0].m     = mean_anomaly_i;
  assign item[0].lower = 32'd0;

  // step s tests lower + 2^(31-s)
  for (genvar s = 0; s < NSteps; s++) begin : g_step
    kea_step u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .half_i     (32'h8000_0000 >> s),
      .ecc_i      (ecc_q),
      .in_vld_i   (vld[s]),
      .in_item_i  (item[s]),
      .out_vld_o  (vld[s+1]),
      .out_item_o (item[s+1])
    );
  end

  assign out_valid_o      = vld[NSteps];
  assign solved_anomaly_o = item[NSteps].byp ? item[NSteps].m : item[NSteps].lower;

endmodule

[rtl/core/kea_step.sv]
// ----------------------------------------------------------------------------
// kea_step
// One bisection step: midpoint, sine, residual sign, new lower bound.
// ----------------------------------------------------------------------------
module kea_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [31:0]         half_i,
  input  logic [15:0]         ecc_i,
  input  logic                in_vld_i,
  input  kea_pkg::item_t      in_item_i,
  output logic                out_vld_o,
  output kea_pkg::item_t      out_item_o
);

  localparam int unsigned NStg = kea_pkg::StepStages;
  localparam int unsigned NTay = kea_pkg::TaylorTerms;

  typedef struct packed {
    kea_pkg::item_t item;
    logic [31:0]    mid;
    logic [30:0]    x;
    logic [31:0]    x2;
  } side_t;

  logic [NStg-1:0] vld_q;
  side_t           side_d [NStg];
  side_t           side_q [NStg];

  logic [30:0] q1_q;
  logic [61:0] xprod_q;
  logic [61:0] x2prod_q;
  logic [62:0] accprod_q [NTay];
  logic [31:0] p_q       [NTay];
  logic [61:0] pm_q      [NTay];
  logic [30:0] acc_q     [NTay];
  logic [61:0] sprod_q;
  logic [46:0] rprod_q;
  logic [61:0] tprod_q;

  logic [31:0] mid0;
  logic [29:0] frac0;
  logic [30:0] q1_d;
  logic [37:0] t_val;
  logic signed [41:0] diff;
  logic signed [41:0] res;

  assign mid0  = in_item_i.lower + half_i;
  assign frac0 = mid0[29:0];
  // odd quadrants mirror the angle
  assign q1_d  = mid0[30] ? (kea_pkg::OneQ30 - {1'b0, frac0}) : {1'b0, frac0};

  assign t_val = tprod_q[61:24];
  assign diff  = $signed({2'b00, side_q[NStg-2].mid, 8'h00})
               - $signed({2'b00, side_q[NStg-2].item.m, 8'h00});
  assign res   = side_q[NStg-2].mid[31] ? (diff + $signed({4'h0, t_val}))
                                        : (diff - $signed({4'h0, t_val}));

  always_comb begin
    side_d[0].item = in_item_i;
    side_d[0].mid  = mid0;
    side_d[0].x    = '0;
    side_d[0].x2   = '0;
    for (int k = 1; k < NStg; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[2].x  = xprod_q[60:30];
    side_d[3].x2 = x2prod_q[61:30];
    if (!(res > 42'sd0)) begin
      side_d[NStg-1].item.lower = side_q[NStg-2].mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NStg; k++) begin
        side_q[k] <= side_d[k];
      end
      q1_q     <= q1_d;
      xprod_q  <= 62'(q1_q) * 62'(kea_pkg::HalfPiQ30);
      x2prod_q <= 62'(xprod_q[60:30]) * 62'(xprod_q[60:30]);
      sprod_q  <= 62'(side_q[20].x) * 62'(acc_q[NTay-1]);
      rprod_q  <= 47'(ecc_i) * 47'(sprod_q[60:30]);
      tprod_q  <= 62'(rprod_q[45:14]) * 62'(kea_pkg::InvTwoPiQ32);
    end
  end

  // Taylor accumulator: three stages per term (product, reciprocal, correction)
  for (genvar i = 0; i < NTay; i++) begin : g_tay
    logic [31:0] x2_sel;
    logic [30:0] acc_prev;
    logic [29:0] q0;
    logic [31:0] rem;
    logic [30:0] quo;

    if (i == 0) begin : g_first
      assign x2_sel   = x2prod_q[61:30];
      assign acc_prev = kea_pkg::OneQ30;
    end else begin : g_rest
      assign x2_sel   = side_q[2+3*i].x2;
      assign acc_prev = acc_q[i-1];
    end

    assign q0  = pm_q[i][61:32];
    assign rem = p_q[i] - 32'(32'(q0) * 32'(kea_pkg::TaylorDiv[i]));
    assign quo = (rem >= 32'(kea_pkg::TaylorDiv[i])) ? (31'(q0) + 31'd1) : 31'(q0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        accprod_q[i] <= 63'(x2_sel) * 63'(acc_prev);
        p_q[i]       <= accprod_q[i][61:30];
        pm_q[i]      <= 62'(accprod_q[i][61:30]) * 62'(kea_pkg::TaylorRcp[i]);
        acc_q[i]     <= kea_pkg::OneQ30 - quo;
      end
    end
  end

  assign out_vld_o  = vld_q[NStg-1];
  assign out_item_o = side_q[NStg-1].item;

endmodule
